[hdl/spherical_point_perspective_projector_macros.svh]
// Assertion helpers for the projector.
`ifndef SPHERICAL_POINT_PERSPECTIVE_PROJECTOR_MACROS_SVH
`define SPHERICAL_POINT_PERSPECTIVE_PROJECTOR_MACROS_SVH

`ifndef SYNTHESIS
`define SPPP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("projector assertion failed");
`define SPPP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("projector assertion failed");
`else
`define SPPP_ASSERT_IMP(lbl, ante, cons)
`define SPPP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[hdl/sppp_pkg.sv]
package sppp_pkg;

    localparam int AngleBits    = 16;
    localparam int SineFracBits = 15;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CfgViewRadius    = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgViewAzimuth   = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgViewElevation = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgImageWidth    = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgImageHeight   = 3'd4;

    localparam logic [15:0] ResetViewRadius  = 16'd50000;
    localparam logic [10:0] ResetImageWidth  = 11'd640;
    localparam logic [10:0] ResetImageHeight = 11'd480;

    // sine polynomial, Q30
    localparam logic [30:0] PolyA   = 31'd1685472545;
    localparam logic [29:0] PolyB   = 30'd686590530;
    localparam logic [26:0] PolyC   = 27'd74859809;
    localparam logic [30:0] Q30One  = 31'h4000_0000;

    localparam int SineShift = 60 - SineFracBits;
    localparam int SineRawW  = 62 - SineShift;
    localparam int SineW     = SineFracBits + 1;
    localparam int MulW      = SineFracBits + 12;
    localparam int ProdW     = 2 * SineFracBits + 13;

    // ceil(2^24 / 100): exact floor division for 16-bit operands
    localparam logic [17:0] Div100Mul = 18'd167773;

    localparam int NumStages = 20;
    localparam int DivSteps  = 10;

    localparam logic [11:0] YOffset   = 12'd1000;
    localparam logic [19:0] ProjPlane = 20'd300;
    localparam logic [10:0] DepthNear = 11'd800;
    localparam logic [10:0] DepthMid  = 11'd1000;
    localparam logic [10:0] DepthFar  = 11'd1200;
    localparam logic [10:0] YMin      = 11'd345;
    localparam logic [10:0] YMax      = 11'd1655;

    typedef struct packed {
        logic [3:0] kind;
        logic       last;
    } t_meta;

endpackage

[hdl/spherical_point_perspective_projector.sv]
// Projects one star per clock while the output does not stall: spherical (radius,
// azimuth, elevation) is zoomed, rotated by the view angles, converted to Cartesian
// with a polynomial sine, projected onto the plane y=300 and centered/clipped to the
// image. The work is done by the 20-stage pipeline (four multiplier stages of the sine
// units, a 10-step restoring divide by depth). A stalled output backs up stage by stage,
// so bubbles are squeezed out before input stalls.
// Configuration writes are taken every cycle and must happen while the pipeline is empty.
`include "spherical_point_perspective_projector_macros.svh"

module spherical_point_perspective_projector
    import sppp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_star_valid,
    output logic                o_star_ready,
    input  logic [15:0]         i_star_radius,
    input  logic [15:0]         i_star_azimuth,
    input  logic [15:0]         i_star_elevation,
    input  logic [3:0]          i_star_kind,
    input  logic                i_last_star,
    output logic                o_point_valid,
    input  logic                i_point_ready,
    output logic signed [11:0]  o_screen_x,
    output logic signed [11:0]  o_screen_y,
    output logic                o_visible,
    output logic [1:0]          o_depth_level,
    output logic [3:0]          o_kind_out,
    output logic                o_last_out
);

    localparam logic [AngleBits-1:0] Quarter = AngleBits'(1) << (AngleBits - 2);
    localparam logic [SineRawW-1:0]  SineMax = SineRawW'((1 << SineFracBits) - 1);
    localparam logic [ProdW-1:0]     XBias   = ProdW'((64'd1 << (2 * SineFracBits)) - 1);
    localparam logic [MulW-1:0]      ZBias   = MulW'((1 << SineFracBits) - 1);

    // configuration
    logic [15:0] r_view_radius, r_view_az, r_view_el;
    logic [10:0] r_img_w, r_img_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_radius <= ResetViewRadius;
            r_view_az     <= '0;
            r_view_el     <= '0;
            r_img_w       <= ResetImageWidth;
            r_img_h       <= ResetImageHeight;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgViewRadius:    r_view_radius <= i_cfg_data;
                CfgViewAzimuth:   r_view_az     <= i_cfg_data;
                CfgViewElevation: r_view_el     <= i_cfg_data;
                CfgImageWidth:    r_img_w       <= i_cfg_data[10:0];
                CfgImageHeight:   r_img_h       <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // flow control: a stage moves when it is empty or the next one moves
    logic [NumStages:1] r_vld;
    logic [NumStages:1] en;
    logic [NumStages:1] vld_in;
    t_meta              r_meta [1:NumStages];

    always_comb begin
        en[NumStages] = !r_vld[NumStages] || i_point_ready;
        for (int k = NumStages - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign vld_in       = {r_vld[NumStages-1:1], i_star_valid};
    assign o_star_ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NumStages; k++) begin
                if (en[k]) r_vld[k] <= vld_in[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) r_meta[1] <= '{kind: i_star_kind, last: i_last_star};
        for (int k = 2; k <= NumStages; k++) begin
            if (en[k]) r_meta[k] <= r_meta[k-1];
        end
    end

    // stage 1: zoom product, phases
    logic [31:0]          r_prod1;
    logic [AngleBits-1:0] r_pa1, r_pe1;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_prod1 <= i_star_radius * r_view_radius;
            r_pa1   <= i_star_azimuth[AngleBits-1:0] + r_view_az[AngleBits-1:0];
            r_pe1   <= i_star_elevation[AngleBits-1:0] + r_view_el[AngleBits-1:0];
        end
    end

    // stage 2: divide by 65535, fold phases into quadrant, w^2
    // lanes: 0 sin az, 1 cos az, 2 sin el, 3 cos el
    logic [AngleBits-1:0] n_ph   [4];
    logic [30:0]          n_w    [4];
    logic [61:0]          n_wsq  [4];
    logic [29:0]          n_frac [4];
    logic [32:0]          n_qsum;
    logic [16:0]          n_q0;
    logic [33:0]          n_rem;
    logic [15:0]          n_q;

    always_comb begin
        n_ph[0] = r_pa1;
        n_ph[1] = r_pa1 + Quarter;
        n_ph[2] = r_pe1;
        n_ph[3] = r_pe1 + Quarter;
        for (int l = 0; l < 4; l++) begin
            n_frac[l] = {n_ph[l][AngleBits-3:0], {(32 - AngleBits){1'b0}}};
            n_w[l]    = n_ph[l][AngleBits-2] ? (Q30One - {1'b0, n_frac[l]})
                                             : {1'b0, n_frac[l]};
            n_wsq[l]  = n_w[l] * n_w[l];
        end
        n_qsum = {1'b0, r_prod1} + {17'd0, r_prod1[31:16]};
        n_q0   = n_qsum[32:16];
        n_rem  = {2'b0, r_prod1} + {17'd0, n_q0} - {1'b0, n_q0, 16'd0};
        n_q    = (n_rem >= 34'd65535) ? 16'(n_q0 + 17'd1) : n_q0[15:0];
    end

    logic [15:0] r_q2;
    logic [30:0] r_w2_2 [4];
    logic [30:0] r_w_2  [4];
    logic [1:0]  r_quad2 [4];

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_q2 <= n_q;
            for (int l = 0; l < 4; l++) begin
                r_w2_2[l]  <= n_wsq[l][60:30];
                r_w_2[l]   <= n_w[l];
                r_quad2[l] <= n_ph[l][AngleBits-1:AngleBits-2];
            end
        end
    end

    // stage 3: radius / 100, C*w2
    logic [33:0] n_srp;
    logic [57:0] n_t1p [4];

    always_comb begin
        n_srp = r_q2 * Div100Mul;
        for (int l = 0; l < 4; l++) n_t1p[l] = PolyC * r_w2_2[l];
    end

    logic [9:0]  r_sr3;
    logic [26:0] r_t1_3  [4];
    logic [30:0] r_w2_3  [4];
    logic [30:0] r_w_3   [4];
    logic [1:0]  r_quad3 [4];

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_sr3 <= n_srp[33:24];
            for (int l = 0; l < 4; l++) begin
                r_t1_3[l]  <= n_t1p[l][56:30];
                r_w2_3[l]  <= r_w2_2[l];
                r_w_3[l]   <= r_w_2[l];
                r_quad3[l] <= r_quad2[l];
            end
        end
    end

    // stage 4: (B - t1)*w2
    logic [60:0] n_t2p [4];

    always_comb begin
        for (int l = 0; l < 4; l++) n_t2p[l] = (PolyB - {3'd0, r_t1_3[l]}) * r_w2_3[l];
    end

    logic [9:0]  r_sr4;
    logic [29:0] r_t2_4  [4];
    logic [30:0] r_w_4   [4];
    logic [1:0]  r_quad4 [4];

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_sr4 <= r_sr3;
            for (int l = 0; l < 4; l++) begin
                r_t2_4[l]  <= n_t2p[l][59:30];
                r_w_4[l]   <= r_w_3[l];
                r_quad4[l] <= r_quad3[l];
            end
        end
    end

    // stage 5: (A - t2)*w, scaled to the output fraction
    logic [61:0] n_sp [4];

    always_comb begin
        for (int l = 0; l < 4; l++) n_sp[l] = (PolyA - {1'b0, r_t2_4[l]}) * r_w_4[l];
    end

    logic [9:0]          r_sr5;
    logic [SineRawW-1:0] r_sraw5 [4];
    logic [1:0]          r_quad5 [4];

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_sr5 <= r_sr4;
            for (int l = 0; l < 4; l++) begin
                r_sraw5[l] <= n_sp[l][61:SineShift];
                r_quad5[l] <= r_quad4[l];
            end
        end
    end

    // stage 6: saturate and sign
    logic [SineRawW-1:0] n_mag [4];
    logic [SineW-1:0]    n_sin [4];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            n_mag[l] = (r_sraw5[l] > SineMax) ? SineMax : r_sraw5[l];
            n_sin[l] = r_quad5[l][1] ? SineW'(-n_mag[l][SineW-1:0]) : n_mag[l][SineW-1:0];
        end
    end

    logic [9:0]              r_sr6;
    logic signed [SineW-1:0] r_sin6 [4];

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_sr6 <= r_sr5;
            for (int l = 0; l < 4; l++) r_sin6[l] <= n_sin[l];
        end
    end

    // stage 7: sr*cos(az), sr*sin(az), z
    logic signed [MulW-1:0] n_mx, n_my, n_zp, n_zb, n_zs;
    logic signed [10:0]     n_sr_s;

    always_comb begin
        n_sr_s = $signed({1'b0, r_sr6});
        n_mx   = n_sr_s * r_sin6[1];
        n_my   = n_sr_s * r_sin6[0];
        n_zp   = n_sr_s * r_sin6[2];
        n_zb   = n_zp + (n_zp[MulW-1] ? $signed(ZBias) : $signed(MulW'(0)));
        n_zs   = n_zb >>> SineFracBits;
    end

    logic signed [MulW-1:0]  r_mx7, r_my7;
    logic signed [SineW-1:0] r_ct7;
    logic signed [10:0]      r_z7;

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_mx7 <= n_mx;
            r_my7 <= n_my;
            r_ct7 <= r_sin6[3];
            r_z7  <= n_zs[10:0];
        end
    end

    // stage 8: times cos(el), truncate toward zero
    logic signed [ProdW-1:0] n_px, n_py, n_pxb, n_pyb, n_xs, n_ys;
    logic [11:0]             n_y;

    always_comb begin
        n_px  = r_mx7 * r_ct7;
        n_py  = r_my7 * r_ct7;
        n_pxb = n_px + (n_px[ProdW-1] ? $signed(XBias) : $signed(ProdW'(0)));
        n_pyb = n_py + (n_py[ProdW-1] ? $signed(XBias) : $signed(ProdW'(0)));
        n_xs  = n_pxb >>> (2 * SineFracBits);
        n_ys  = n_pyb >>> (2 * SineFracBits);
        n_y   = n_ys[11:0] + YOffset;
    end

    logic signed [10:0] r_x8, r_z8;
    logic [10:0]        r_y8;

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_x8 <= n_xs[10:0];
            r_y8 <= n_y[10:0];
            r_z8 <= r_z7;
        end
    end

    // stage 9: numerators 300*x, 300*z as sign and magnitude; depth level
    logic signed [19:0] n_nx, n_nz;
    logic [19:0]        n_ax, n_az;
    logic [1:0]         n_depth;

    always_comb begin
        n_nx = $signed(r_x8) * $signed(ProjPlane);
        n_nz = $signed(r_z8) * $signed(ProjPlane);
        n_ax = n_nx[19] ? 20'(-n_nx) : n_nx;
        n_az = n_nz[19] ? 20'(-n_nz) : n_nz;
        if (r_y8 < DepthNear)     n_depth = 2'd3;
        else if (r_y8 < DepthMid) n_depth = 2'd2;
        else if (r_y8 < DepthFar) n_depth = 2'd1;
        else                      n_depth = 2'd0;
    end

    // divider: entry 0 is stage 9, entry d+1 is stage 10+d
    logic [17:0]         r_rx  [DivSteps+1];
    logic [17:0]         r_rz  [DivSteps+1];
    logic [DivSteps-1:0] r_qx  [DivSteps+1];
    logic [DivSteps-1:0] r_qz  [DivSteps+1];
    logic [10:0]         r_dy  [DivSteps+1];
    logic                r_nx  [DivSteps+1];
    logic                r_nz  [DivSteps+1];
    logic [1:0]          r_dep [DivSteps+1];

    logic [19:0]         n_dsh [DivSteps];
    logic                n_gex [DivSteps];
    logic                n_gez [DivSteps];
    logic [17:0]         n_rx  [DivSteps];
    logic [17:0]         n_rz  [DivSteps];

    always_comb begin
        for (int d = 0; d < DivSteps; d++) begin
            n_dsh[d] = {9'd0, r_dy[d]} << (DivSteps - 1 - d);
            n_gex[d] = {2'b0, r_rx[d]} >= n_dsh[d];
            n_gez[d] = {2'b0, r_rz[d]} >= n_dsh[d];
            n_rx[d]  = n_gex[d] ? 18'({2'b0, r_rx[d]} - n_dsh[d]) : r_rx[d];
            n_rz[d]  = n_gez[d] ? 18'({2'b0, r_rz[d]} - n_dsh[d]) : r_rz[d];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r_rx[0]  <= n_ax[17:0];
            r_rz[0]  <= n_az[17:0];
            r_qx[0]  <= '0;
            r_qz[0]  <= '0;
            r_dy[0]  <= r_y8;
            r_nx[0]  <= n_nx[19];
            r_nz[0]  <= n_nz[19];
            r_dep[0] <= n_depth;
        end
        for (int d = 0; d < DivSteps; d++) begin
            if (en[10+d]) begin
                r_rx[d+1]  <= n_rx[d];
                r_rz[d+1]  <= n_rz[d];
                r_qx[d+1]  <= r_qx[d] | (DivSteps'(n_gex[d]) << (DivSteps - 1 - d));
                r_qz[d+1]  <= r_qz[d] | (DivSteps'(n_gez[d]) << (DivSteps - 1 - d));
                r_dy[d+1]  <= r_dy[d];
                r_nx[d+1]  <= r_nx[d];
                r_nz[d+1]  <= r_nz[d];
                r_dep[d+1] <= r_dep[d];
            end
        end
    end

    // stage 20: sign, center, clip
    logic [11:0] n_qxe, n_qze, n_sx, n_sy;
    logic        n_vis;

    always_comb begin
        n_qxe = {2'b0, r_qx[DivSteps]};
        n_qze = {2'b0, r_qz[DivSteps]};
        n_sx  = (r_nx[DivSteps] ? 12'(-n_qxe) : n_qxe) + {2'b0, r_img_w[10:1]};
        n_sy  = (r_nz[DivSteps] ? 12'(-n_qze) : n_qze) + {2'b0, r_img_h[10:1]};
        n_vis = !n_sx[11] && (n_sx <= {1'b0, r_img_w}) &&
                !n_sy[11] && (n_sy <= {1'b0, r_img_h});
    end

    always_ff @(posedge i_clk) begin
        if (en[NumStages]) begin
            o_screen_x    <= n_sx;
            o_screen_y    <= n_sy;
            o_visible     <= n_vis;
            o_depth_level <= r_dep[DivSteps];
        end
    end

    assign o_point_valid = r_vld[NumStages];
    assign o_kind_out    = r_meta[NumStages].kind;
    assign o_last_out    = r_meta[NumStages].last;

    `SPPP_ASSERT_IMP(a_backpressure, !o_star_ready, o_point_valid && !i_point_ready)
    `SPPP_ASSERT_IMP(a_depth_range, r_vld[9], r_dy[0] >= YMin && r_dy[0] <= YMax)
    `SPPP_ASSERT_IMP(a_visible_sign, o_point_valid && o_visible, !o_screen_x[11] && !o_screen_y[11])
    `SPPP_ASSERT_NXT(a_fill, i_star_valid && o_star_ready, r_vld[1])

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import sppp_pkg::*;

    typedef struct packed {
        logic [11:0] sx;
        logic [11:0] sy;
        logic        vis;
        logic [1:0]  depth;
        logic [3:0]  kind;
        logic        last;
    } t_point;

    typedef struct {
        logic [15:0] rad;
        logic [15:0] az;
        logic [15:0] el;
        logic [3:0]  kind;
        logic        last;
        bit          fixed;   // expected point typed in below
        t_point      pt;
    } t_star_row;

    localparam longint unsigned SineA = 64'd1685472545;
    localparam longint unsigned SineB = 2 * SineA - 64'd2684354560;
    localparam longint unsigned SineC = SineA - 64'd1610612736;
    localparam int CycleLimit = 400000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    logic              i_star_valid = 1'b0;
    logic [15:0]       i_star_radius = '0;
    logic [15:0]       i_star_azimuth = '0;
    logic [15:0]       i_star_elevation = '0;
    logic [3:0]        i_star_kind = '0;
    logic              i_last_star = 1'b0;
    logic              i_point_ready = 1'b0;
    logic              o_cfg_ready;
    logic              o_star_ready;
    logic              o_point_valid;
    logic signed [11:0] o_screen_x;
    logic signed [11:0] o_screen_y;
    logic              o_visible;
    logic [1:0]        o_depth_level;
    logic [3:0]        o_kind_out;
    logic              o_last_out;

    // shadow copy of the view registers
    logic [15:0] zoom_radius = ResetViewRadius;
    logic [15:0] view_az = '0;
    logic [15:0] view_el = '0;
    logic [10:0] img_w = ResetImageWidth;
    logic [10:0] img_h = ResetImageHeight;

    t_point pending_points[$];
    int     errors = 0;
    int     cycles = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;

    spherical_point_perspective_projector dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_point_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic longint q15_sine(logic [31:0] u);
        longint unsigned w, w2, t, s;
        w = u[29:0];
        if (u[30]) w = 64'h4000_0000 - w;
        w2 = (w * w) >> 30;
        t = (SineC * w2) >> 30;
        t = SineB - t;
        t = (t * w2) >> 30;
        t = SineA - t;
        s = (t * w) >> 30;
        s = s >> 15;
        if (s > 32767) s = 32767;
        return u[31] ? -longint'(s) : longint'(s);
    endfunction

    function automatic t_point project_star(logic [15:0] rad, logic [15:0] az,
                                            logic [15:0] el, logic [3:0] kind, logic last);
        longint unsigned prod;
        longint sr, sa, ca, se, ce, x, y, z, sx, sy;
        logic [31:0] pa, pe;
        t_point p;
        prod = longint'(rad) * longint'(zoom_radius);
        sr = longint'(prod / 65535 / 100);
        pa = {16'(az + view_az), 16'h0};
        pe = {16'(el + view_el), 16'h0};
        sa = q15_sine(pa);
        ca = q15_sine(pa + 32'h4000_0000);
        se = q15_sine(pe);
        ce = q15_sine(pe + 32'h4000_0000);
        x = (sr * ca * ce) / (64'sd1 << 30);
        y = (sr * sa * ce) / (64'sd1 << 30) + 1000;
        z = (sr * se) / (64'sd1 << 15);
        sx = (300 * x) / y + longint'(img_w >> 1);
        sy = (300 * z) / y + longint'(img_h >> 1);
        p.sx = sx[11:0];
        p.sy = sy[11:0];
        p.vis = (sx >= 0 && sx <= img_w && sy >= 0 && sy <= img_h);
        p.depth = (y < 800) ? 2'd3 : (y < 1000) ? 2'd2 : (y < 1200) ? 2'd1 : 2'd0;
        p.kind = kind;
        p.last = last;
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_point e;
        if (i_rst_n && o_point_valid && i_point_ready) begin
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected point transfer x=%0d y=%0d", $time,
                         o_screen_x, o_screen_y);
                errors++;
            end else begin
                e = pending_points.pop_front();
                if (o_screen_x !== e.sx) begin
                    $display("%0t: screen_x exp %0d got %0d", $time, $signed(e.sx), o_screen_x);
                    errors++;
                end
                if (o_screen_y !== e.sy) begin
                    $display("%0t: screen_y exp %0d got %0d", $time, $signed(e.sy), o_screen_y);
                    errors++;
                end
                if (o_visible !== e.vis) begin
                    $display("%0t: visible exp %0d got %0d", $time, e.vis, o_visible);
                    errors++;
                end
                if (o_depth_level !== e.depth) begin
                    $display("%0t: depth exp %0d got %0d", $time, e.depth, o_depth_level);
                    errors++;
                end
                if (o_kind_out !== e.kind) begin
                    $display("%0t: kind exp %0d got %0d", $time, e.kind, o_kind_out);
                    errors++;
                end
                if (o_last_out !== e.last) begin
                    $display("%0t: last exp %0d got %0d", $time, e.last, o_last_out);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CfgViewRadius:    zoom_radius = data;
            CfgViewAzimuth:   view_az = data;
            CfgViewElevation: view_el = data;
            CfgImageWidth:    img_w = data[10:0];
            CfgImageHeight:   img_h = data[10:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_star(logic [15:0] rad, logic [15:0] az, logic [15:0] el,
                             logic [3:0] kind, logic last, bit fixed, t_point pt);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_star_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_star_valid <= 1'b1;
        i_star_radius <= rad;
        i_star_azimuth <= az;
        i_star_elevation <= el;
        i_star_kind <= kind;
        i_last_star <= last;
        do @(posedge i_clk); while (!o_star_ready);
        pending_points.push_back(fixed ? pt : project_star(rad, az, el, kind, last));
    endtask

    // lower valid, wait for the pipeline to empty, then let it settle
    task automatic drain();
        @(negedge i_clk);
        i_star_valid <= 1'b0;
        wait (pending_points.size() == 0);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(3))
            0: return 16'($urandom_range(3) * 16'h4000 + $urandom_range(4) - 2);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        t_star_row rows[$];
        t_star_row r;
        t_point centre;
        t_point none;
        int phase_pct[4][2];
        none = '0;
        centre = '{sx: 12'd320, sy: 12'd240, vis: 1'b1, depth: 2'd1, kind: 4'd0, last: 1'b0};
        phase_pct = '{'{0, 0}, '{47, 0}, '{0, 47}, '{18, 18}};

        // zero radius lands on the center at depth 1
        r = '{16'h0000, 16'h0000, 16'h0000, 4'h0, 1'b0, 1'b1, centre};
        rows.push_back(r);
        centre.kind = 4'hf; centre.last = 1'b1;
        r = '{16'h0000, 16'hffff, 16'hffff, 4'hf, 1'b1, 1'b1, centre};
        rows.push_back(r);
        centre.kind = 4'h5; centre.last = 1'b0;
        r = '{16'h0000, 16'h8000, 16'h4000, 4'h5, 1'b0, 1'b1, centre};
        rows.push_back(r);
        r = '{16'hffff, 16'h0000, 16'h0000, 4'h1, 1'b0, 1'b0, none}; rows.push_back(r);
        r = '{16'hffff, 16'h4000, 16'h0000, 4'h2, 1'b0, 1'b0, none}; rows.push_back(r);
        r = '{16'hffff, 16'h8000, 16'h0000, 4'h3, 1'b0, 1'b0, none}; rows.push_back(r);
        r = '{16'hffff, 16'hc000, 16'h0000, 4'h4, 1'b0, 1'b0, none}; rows.push_back(r);
        r = '{16'hffff, 16'h0000, 16'h4000, 4'h6, 1'b0, 1'b0, none}; rows.push_back(r);
        r = '{16'hffff, 16'h0000, 16'hc000, 4'h7, 1'b1, 1'b0, none}; rows.push_back(r);
        r = '{16'hffff, 16'hffff, 16'hffff, 4'h8, 1'b0, 1'b0, none}; rows.push_back(r);
        r = '{16'hffff, 16'h3fff, 16'h7fff, 4'h9, 1'b0, 1'b0, none}; rows.push_back(r);
        r = '{16'hffff, 16'hc001, 16'h2000, 4'ha, 1'b0, 1'b0, none}; rows.push_back(r);
        r = '{16'h0001, 16'h1234, 16'h5678, 4'hb, 1'b0, 1'b0, none}; rows.push_back(r);
        r = '{16'h8000, 16'ha5a5, 16'h5a5a, 4'hc, 1'b1, 1'b0, none}; rows.push_back(r);
        r = '{16'h7fff, 16'h2000, 16'he000, 4'hd, 1'b0, 1'b0, none}; rows.push_back(r);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i])
            send_star(rows[i].rad, rows[i].az, rows[i].el, rows[i].kind, rows[i].last,
                      rows[i].fixed, rows[i].pt);
        drain();

        // zero zoom: everything collapses onto the center
        write_reg(CfgViewRadius, 16'h0000);
        centre = '{sx: 12'd320, sy: 12'd240, vis: 1'b1, depth: 2'd1, kind: 4'h3, last: 1'b1};
        send_star(16'hffff, 16'h4000, 16'h1000, 4'h3, 1'b1, 1'b1, centre);
        send_star(16'hffff, 16'hc000, 16'hffff, 4'h3, 1'b1, 1'b0, none);
        drain();

        // extremes of the view registers, upper data bits above the image width field set
        write_reg(CfgViewRadius, 16'hffff);
        write_reg(CfgViewAzimuth, 16'hffff);
        write_reg(CfgViewElevation, 16'hffff);
        write_reg(CfgImageWidth, 16'hffff);
        write_reg(CfgImageHeight, 16'h0000);
        write_reg(3'd5, 16'h1111);
        write_reg(3'd7, 16'hffff);
        send_star(16'hffff, 16'h0001, 16'h0001, 4'h0, 1'b0, 1'b0, none);
        send_star(16'hffff, 16'h4001, 16'hc001, 4'hf, 1'b1, 1'b0, none);
        send_star(16'h0000, 16'h0000, 16'h0000, 4'h0, 1'b0, 1'b0, none);
        drain();

        for (int blk = 0; blk < 16; blk++) begin
            send_idle_pct = phase_pct[blk % 4][0];
            recv_stall_pct = phase_pct[blk % 4][1];
            write_reg(CfgViewRadius, (blk % 5 == 0) ? 16'd50000 : rand_word());
            write_reg(CfgViewAzimuth, rand_angle());
            write_reg(CfgViewElevation, rand_angle());
            write_reg(CfgImageWidth, (blk == 3) ? 16'h0000 : 16'($urandom));
            write_reg(CfgImageHeight, (blk == 7) ? 16'h07ff : 16'($urandom));
            if (blk % 3 == 0)
                write_reg(3'($urandom_range(7, 5)), 16'($urandom));
            for (int n = 0; n < 90; n++)
                send_star(($urandom_range(3) == 0) ? rand_word() : 16'($urandom),
                          rand_angle(), rand_angle(), 4'($urandom),
                          ($urandom_range(7) == 0), 1'b0, none);
            drain();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

[spherical_point_perspective_projector.f]
+incdir+hdl
hdl/sppp_pkg.sv
hdl/spherical_point_perspective_projector.sv
test/testbench.sv
